// ===== rtl/hex_record_stream_parser_defines.svh =====
// Assertion macros for the hex record stream parser.
`ifndef HEX_RECORD_STREAM_PARSER_DEFINES_SVH
`define HEX_RECORD_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define HRSP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define HRSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HRSP_ASSERT(lbl, cond, msg)
`define HRSP_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/hrsp_pkg.sv =====
// Shared types and constants for the hex record stream parser.
package hrsp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_ENDED      = 10'd1023;
  localparam logic [POS_W-1:0] POS_MAX        = 10'd1022;
  localparam logic [POS_W-1:0] POS_COUNT      = 10'd1;
  localparam logic [POS_W-1:0] POS_ADDR_HI    = 10'd3;
  localparam logic [POS_W-1:0] POS_ADDR_LO    = 10'd5;
  localparam logic [POS_W-1:0] POS_TYPE       = 10'd7;
  localparam logic [POS_W-1:0] FIRST_DATA_POS = 10'd9;

  localparam logic [7:0] TYPE_EOF = 8'd1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [3:0] NIB_TEN = 4'd10;

  // Classified character passed from front to back.
  typedef struct packed {
    logic       is_space;
    logic [3:0] nibble;
  } token_t;

endpackage

// ===== rtl/hrsp_front.sv =====
// Front end: classifies each character and queues the resulting token.
module hrsp_front #(
  parameter int unsigned QUEUE_DEPTH = hrsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_ch,
  output logic            tok_valid,
  input  logic            tok_pop,
  output hrsp_pkg::token_t tok
);
  import hrsp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  token_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  token_t             new_tok;
  logic               push, pop;

  always_comb begin
    new_tok.is_space = (in_ch == CH_SP) || (in_ch inside {[CH_TAB:CH_CR]});
    if (in_ch inside {[CH_A:CH_F]}) begin
      new_tok.nibble = 4'(in_ch - CH_A) + NIB_TEN;
    end else if (in_ch inside {[CH_0:CH_9]}) begin
      new_tok.nibble = 4'(in_ch - CH_0);
    end else begin
      new_tok.nibble = 4'd0;
    end
  end

  assign in_ready  = (count_r != CNT_FULL);
  assign tok_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = tok_pop && tok_valid;
  assign tok       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_tok;
    end
  end

endmodule

// ===== rtl/hrsp_back.sv =====
// Back end: record parser state and the registered result stage.
module hrsp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  output logic             tok_pop,
  input  hrsp_pkg::token_t tok,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [15:0]      out_byte_address,
  output logic [7:0]       out_byte_value
);
  import hrsp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic             ov_r, ov_nxt;
  logic             okind_r, okind_nxt;
  logic [15:0]      oaddr_r, oaddr_nxt;
  logic [7:0]       oval_r, oval_nxt;

  logic             advance;
  logic             emit;
  logic [7:0]       byte_v;
  logic [POS_W-1:0] data_off;
  logic [POS_W-2:0] k;

  // Take a token when the result stage is empty or drains this cycle.
  assign advance = tok_valid && (!ov_r || out_ready);
  assign tok_pop = advance;

  assign byte_v   = {hi_r, tok.nibble};
  assign data_off = pos_r - FIRST_DATA_POS;
  assign k        = data_off[POS_W-1:1];

  always_comb begin
    pos_nxt   = pos_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    emit      = 1'b0;
    okind_nxt = okind_r;
    oaddr_nxt = oaddr_r;
    oval_nxt  = oval_r;
    if (advance && (pos_r != POS_ENDED)) begin
      if (tok.is_space) begin
        pos_nxt = '0;
      end else begin
        if (pos_r < POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (!pos_r[0]) begin
          hi_nxt = tok.nibble;
        end else begin
          case (pos_r)
            POS_COUNT:   cnt_nxt = byte_v;
            POS_ADDR_HI: addr_nxt = {byte_v, 8'd0};
            POS_ADDR_LO: addr_nxt = {addr_r[15:8], byte_v};
            POS_TYPE: begin
              if (byte_v == TYPE_EOF) begin
                pos_nxt   = POS_ENDED;
                emit      = 1'b1;
                okind_nxt = KIND_EOF;
                oaddr_nxt = addr_r;
                oval_nxt  = 8'd0;
              end
            end
            default: begin
              if ((pos_r >= FIRST_DATA_POS) && (k < {1'b0, cnt_r})) begin
                emit      = 1'b1;
                okind_nxt = KIND_DATA;
                oaddr_nxt = addr_r + 16'(k);
                oval_nxt  = byte_v;
              end
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (advance) begin
      ov_nxt = emit;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hi_r   <= '0;
      cnt_r  <= '0;
      addr_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      hi_r   <= hi_nxt;
      cnt_r  <= cnt_nxt;
      addr_r <= addr_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    oaddr_r <= oaddr_nxt;
    oval_r  <= oval_nxt;
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_byte_address = oaddr_r;
  assign out_byte_value   = oval_r;

endmodule

// ===== rtl/hex_record_stream_parser.sv =====
// Top level of the hex record stream parser.
//
//  channel | direction | payload                                  | handshake
//  in      | input     | ch[7:0]                                  | in_valid / in_ready
//  out     | output    | kind, byte_address[15:0], byte_value[7:0]| out_valid / out_ready
//
// One character per cycle sustained while out_ready stays high; a result is valid
// once its character has passed the token queue and then the parser's result
// register.
// The queue holds QUEUE_DEPTH tokens; in_ready drops only when it is full.
// Synchronous active-low reset clears the queue, parser state and out_valid.
// A stalled out_ready backs up into the queue and then into in_ready.
`include "hex_record_stream_parser_defines.svh"

module hex_record_stream_parser #(
  parameter int unsigned QUEUE_DEPTH = hrsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] out_byte_address,
  output logic [7:0]  out_byte_value
);
  import hrsp_pkg::*;

  logic   tok_valid;
  logic   tok_pop;
  token_t tok;

  hrsp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .tok_valid(tok_valid),
    .tok_pop  (tok_pop),
    .tok      (tok)
  );

  hrsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .tok_valid       (tok_valid),
    .tok_pop         (tok_pop),
    .tok             (tok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte_address(out_byte_address),
    .out_byte_value  (out_byte_value)
  );

  `HRSP_ASSERT_NEXT(a_push_fills, in_valid && in_ready, tok_valid, "queue empty after a transfer")
  `HRSP_ASSERT(a_empty_ready, tok_valid || in_ready, "input stalled with an empty queue")
  `HRSP_ASSERT_NEXT(a_eof_last, out_valid && out_ready && out_kind, !out_valid, "result after eof")

endmodule
